[sv/mfk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfk_pkg: shared types, constants and the micro-program
// Holds the operation codes, the variable map of the working store, the
// request and response words of the shared arithmetic unit and the
// sequencer program that evaluates the fringe map.
// ----------------------------------------------------------------------------
package mfk_pkg;

  localparam int VAW  = 6;   // working store address width
  localparam int VDEP = 64;  // working store depth
  localparam int PCW  = 7;   // program counter width
  localparam int KW   = 6;   // scaling numerator magnitude width
  localparam int MW   = 8;   // scaling divisor width
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 4;

  localparam logic [CFG_IW-1:0] CFG_EDGE_SIGN = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SKIP_DIP  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TOP_ORDER = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRACK = 1'b1;

  typedef enum logic [3:0] {
    OP_LDIN, OP_LDCN, OP_LDCS, OP_ADD, OP_SUB, OP_NEG, OP_N48, OP_SELF,
    OP_MUL, OP_DIV, OP_SCLE, OP_SCLJ, OP_SCLP, OP_LOOP, OP_DONE
  } op_t;

  typedef enum logic [1:0] {CM_MUL, CM_DIV, CM_SCL} core_mode_t;

  typedef enum logic [2:0] {CS_IDLE, CS_MUL, CS_DIV, CS_RND, CS_FIN} core_state_t;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EXEC, ST_WAIT, ST_DONE} seq_state_t;

  typedef struct packed {
    logic           start;
    core_mode_t     mode;
    logic [KW-1:0]  kmag;
    logic           kneg;
    logic [MW-1:0]  m;
  } core_req_t;

  typedef struct packed {
    logic done;
    logic fault;
  } core_rsp_t;

  typedef struct packed {
    op_t            op;
    logic [VAW-1:0] d;
    logic [VAW-1:0] a;
    logic [VAW-1:0] b;
  } instr_t;

  // Input selectors, carried in the a field of a load-input instruction.
  localparam logic [VAW-1:0] IN_X = 6'd0, IN_PX = 6'd1, IN_Y = 6'd2, IN_PY = 6'd3;
  localparam logic [VAW-1:0] IN_DL = 6'd4, IN_CT = 6'd5, IN_ONE = 6'd6, IN_ZERO = 6'd7;

  // Working store map.
  localparam logic [VAW-1:0] V_ZERO = 6'd0,  V_ONE = 6'd1,  V_X = 6'd2,   V_PX = 6'd3;
  localparam logic [VAW-1:0] V_Y = 6'd4,     V_PY = 6'd5,   V_DL = 6'd6,  V_CT = 6'd7;
  localparam logic [VAW-1:0] V_RX = 6'd8,    V_IX = 6'd9,   V_FX = 6'd10, V_FY = 6'd11;
  localparam logic [VAW-1:0] V_FXX = 6'd12,  V_FXY = 6'd13, V_FYX = 6'd14, V_FYY = 6'd15;
  localparam logic [VAW-1:0] V_BN = 6'd16,   V_AN = 6'd17,  V_DRX = 6'd18, V_DIX = 6'd19;
  localparam logic [VAW-1:0] V_U = 6'd20,    V_V = 6'd21,   V_DU = 6'd22, V_DV = 6'd23;
  localparam logic [VAW-1:0] V_DUX = 6'd24,  V_DVX = 6'd25, V_DUY = 6'd26, V_NV = 6'd27;
  localparam logic [VAW-1:0] V_NX = 6'd28,   V_NY = 6'd29,  V_T1 = 6'd30, V_T2 = 6'd31;
  localparam logic [VAW-1:0] V_DEL = 6'd32,  V_MA = 6'd33,  V_MB = 6'd34, V_MC = 6'd35;
  localparam logic [VAW-1:0] V_MD = 6'd36,   V_XO = 6'd37,  V_YO = 6'd38, V_DET = 6'd39;
  localparam logic [VAW-1:0] V_QX = 6'd40,   V_QY = 6'd41,  V_PXO = 6'd42, V_PYO = 6'd43;
  localparam logic [VAW-1:0] V_CTO = 6'd44;

  localparam int PROG_LEN = 118;
  localparam logic [PCW-1:0] LOOP_START = 7'd16;

  localparam instr_t PROG [PROG_LEN] = '{
    // set-up
    '{OP_LDIN, V_ONE, IN_ONE, V_ZERO},  '{OP_LDIN, V_ZERO, IN_ZERO, V_ZERO},
    '{OP_LDIN, V_X, IN_X, V_ZERO},      '{OP_LDIN, V_PX, IN_PX, V_ZERO},
    '{OP_LDIN, V_Y, IN_Y, V_ZERO},      '{OP_LDIN, V_PY, IN_PY, V_ZERO},
    '{OP_LDIN, V_DL, IN_DL, V_ZERO},    '{OP_LDIN, V_CT, IN_CT, V_ZERO},
    '{OP_LDIN, V_RX, IN_ONE, V_ZERO},   '{OP_LDIN, V_IX, IN_ZERO, V_ZERO},
    '{OP_LDIN, V_FX, IN_ZERO, V_ZERO},  '{OP_LDIN, V_FY, IN_ZERO, V_ZERO},
    '{OP_LDIN, V_FXX, IN_ZERO, V_ZERO}, '{OP_LDIN, V_FXY, IN_ZERO, V_ZERO},
    '{OP_LDIN, V_FYX, IN_ZERO, V_ZERO}, '{OP_LDIN, V_FYY, IN_ZERO, V_ZERO},
    // per-order body
    '{OP_LDCN, V_BN, V_ZERO, V_ZERO},   '{OP_LDCS, V_AN, V_ZERO, V_ZERO},
    '{OP_ADD, V_DRX, V_RX, V_ZERO},     '{OP_ADD, V_DIX, V_IX, V_ZERO},
    '{OP_MUL, V_T1, V_DRX, V_X},        '{OP_MUL, V_T2, V_DIX, V_Y},
    '{OP_SUB, V_RX, V_T1, V_T2},
    '{OP_MUL, V_T1, V_DRX, V_Y},        '{OP_MUL, V_T2, V_DIX, V_X},
    '{OP_ADD, V_IX, V_T1, V_T2},
    '{OP_MUL, V_T1, V_BN, V_RX},        '{OP_MUL, V_T2, V_AN, V_IX},
    '{OP_SUB, V_U, V_T1, V_T2},
    '{OP_MUL, V_T1, V_BN, V_IX},        '{OP_MUL, V_T2, V_AN, V_RX},
    '{OP_ADD, V_V, V_T1, V_T2},
    '{OP_MUL, V_T1, V_BN, V_DRX},       '{OP_MUL, V_T2, V_AN, V_DIX},
    '{OP_SUB, V_DU, V_T1, V_T2},
    '{OP_MUL, V_T1, V_BN, V_DIX},       '{OP_MUL, V_T2, V_AN, V_DRX},
    '{OP_ADD, V_DV, V_T1, V_T2},
    '{OP_SCLE, V_U, V_U, V_ZERO},       '{OP_SCLE, V_V, V_V, V_ZERO},
    '{OP_SCLE, V_DU, V_DU, V_ZERO},     '{OP_SCLE, V_DV, V_DV, V_ZERO},
    '{OP_SCLJ, V_DUX, V_DU, V_ZERO},    '{OP_SCLJ, V_DVX, V_DV, V_ZERO},
    '{OP_NEG, V_DUY, V_DVX, V_ZERO},
    '{OP_SCLP, V_NV, V_V, V_ZERO},      '{OP_SCLP, V_NX, V_X, V_ZERO},
    '{OP_SCLP, V_NY, V_Y, V_ZERO},
    '{OP_MUL, V_T1, V_U, V_X},          '{OP_MUL, V_T2, V_NV, V_Y},
    '{OP_ADD, V_T1, V_T1, V_T2},        '{OP_ADD, V_FX, V_FX, V_T1},
    '{OP_MUL, V_T1, V_U, V_Y},          '{OP_MUL, V_T2, V_NV, V_X},
    '{OP_SUB, V_T1, V_T1, V_T2},        '{OP_ADD, V_FY, V_FY, V_T1},
    '{OP_MUL, V_T1, V_DUX, V_X},        '{OP_ADD, V_T1, V_T1, V_U},
    '{OP_MUL, V_T2, V_NY, V_DVX},       '{OP_ADD, V_T1, V_T1, V_T2},
    '{OP_ADD, V_FXX, V_FXX, V_T1},
    '{OP_MUL, V_T1, V_DUY, V_X},        '{OP_ADD, V_T1, V_T1, V_NV},
    '{OP_MUL, V_T2, V_NY, V_DUX},       '{OP_ADD, V_T1, V_T1, V_T2},
    '{OP_ADD, V_FXY, V_FXY, V_T1},
    '{OP_MUL, V_T1, V_DUX, V_Y},        '{OP_SUB, V_T1, V_T1, V_NV},
    '{OP_MUL, V_T2, V_NX, V_DVX},       '{OP_SUB, V_T1, V_T1, V_T2},
    '{OP_ADD, V_FYX, V_FYX, V_T1},
    '{OP_MUL, V_T1, V_DUY, V_Y},        '{OP_ADD, V_T1, V_T1, V_U},
    '{OP_MUL, V_T2, V_NX, V_DUX},       '{OP_SUB, V_T1, V_T1, V_T2},
    '{OP_ADD, V_FYY, V_FYY, V_T1},
    '{OP_LOOP, V_ZERO, V_ZERO, V_ZERO},
    // closing map
    '{OP_ADD, V_T1, V_ONE, V_DL},       '{OP_DIV, V_DEL, V_ONE, V_T1},
    '{OP_MUL, V_T1, V_FXX, V_DEL},      '{OP_SUB, V_MA, V_ONE, V_T1},
    '{OP_MUL, V_T1, V_FYX, V_DEL},      '{OP_NEG, V_MB, V_T1, V_ZERO},
    '{OP_MUL, V_T1, V_FYY, V_DEL},      '{OP_SUB, V_MD, V_ONE, V_T1},
    '{OP_MUL, V_T1, V_FXY, V_DEL},      '{OP_NEG, V_MC, V_T1, V_ZERO},
    '{OP_MUL, V_T1, V_FX, V_DEL},       '{OP_SUB, V_T1, V_X, V_T1},
    '{OP_N48, V_XO, V_T1, V_ZERO},
    '{OP_MUL, V_T1, V_FY, V_DEL},       '{OP_SUB, V_T1, V_Y, V_T1},
    '{OP_N48, V_YO, V_T1, V_ZERO},
    '{OP_MUL, V_T1, V_MA, V_MD},        '{OP_MUL, V_T2, V_MB, V_MC},
    '{OP_SUB, V_DET, V_T1, V_T2},
    '{OP_MUL, V_T1, V_MD, V_PX},        '{OP_MUL, V_T2, V_MB, V_PY},
    '{OP_SUB, V_T1, V_T1, V_T2},        '{OP_DIV, V_T1, V_T1, V_DET},
    '{OP_N48, V_QX, V_T1, V_ZERO},
    '{OP_MUL, V_T1, V_MA, V_PY},        '{OP_MUL, V_T2, V_MC, V_PX},
    '{OP_SUB, V_T1, V_T1, V_T2},        '{OP_DIV, V_T1, V_T1, V_DET},
    '{OP_N48, V_QY, V_T1, V_ZERO},
    '{OP_SELF, V_PXO, V_PX, V_QX},      '{OP_SELF, V_PYO, V_PY, V_QY},
    '{OP_MUL, V_T1, V_PXO, V_FX},       '{OP_MUL, V_T2, V_PYO, V_FY},
    '{OP_ADD, V_T1, V_T1, V_T2},
    '{OP_MUL, V_T1, V_T1, V_DEL},       '{OP_MUL, V_T1, V_T1, V_DEL},
    '{OP_SUB, V_T1, V_CT, V_T1},        '{OP_N48, V_CTO, V_T1, V_ZERO},
    '{OP_SELF, V_PXO, V_PX, V_PXO},     '{OP_SELF, V_PYO, V_PY, V_PYO},
    '{OP_DONE, V_ZERO, V_ZERO, V_ZERO}
  };

endpackage

[sv/multipole_fringe_kick_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipole_fringe_kick_unit: hard-edge multipole fringe map, fixed point
// A micro-programmed sequencer drives a working store and a shared
// multiply-divide unit to apply the fringe map to one particle per word.
// ----------------------------------------------------------------------------
// Timing: a load word is taken straight from idle. A track word runs the
//   per-order body once per order up to the top order, then the closing
//   map; the bit-serial divider of the shared arithmetic unit (used for
//   divisions and non-unit scalings) and the 32x32 multiplier set its duration.
// Throughput: one word at a time; the next word is taken once the previous
//   result has been placed in the output register.
// Reset: synchronous, active high; clears the coefficient table valid bits
//   (every entry reads zero) and sets edge_sign 1, skip off, top order 0.
// ----------------------------------------------------------------------------
module multipole_fringe_kick_unit #(
  parameter int NUM_ORDERS = 16,
  parameter int FRAC_BITS  = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [mfk_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [mfk_pkg::CFG_DW-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [3:0]                    order_index,
  input  logic signed [63:0]            normal_value,
  input  logic signed [63:0]            skew_value,
  input  logic signed [47:0]            x_in,
  input  logic signed [47:0]            px_in,
  input  logic signed [47:0]            y_in,
  input  logic signed [47:0]            py_in,
  input  logic signed [47:0]            delta_in,
  input  logic signed [47:0]            ct_in,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [47:0]            x_out,
  output logic signed [47:0]            px_out,
  output logic signed [47:0]            y_out,
  output logic signed [47:0]            py_out,
  output logic signed [47:0]            ct_out,
  output logic                          fault
);
  import mfk_pkg::*;

  localparam int AW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam logic [4:0] LAST = 5'(NUM_ORDERS - 1);
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -MAX48 - 64'sd1;

  // Configuration registers.
  logic [1:0] edge_sign;
  logic       skip_normal_dipole;
  logic [3:0] top_order;

  // Sequencer state.
  seq_state_t     state, state_next;
  logic [PCW-1:0] pc, pc_next;
  logic [AW-1:0]  n, n_next;
  logic           flt, flt_next;
  instr_t         ins;
  logic [4:0]     top_lim;
  logic [7:0]     n8;

  // Captured particle.
  logic [47:0] xi, pxi, yi, pyi, dli, cti;
  logic        capture;

  // Store and unit wiring.
  logic        wr_en;
  logic [63:0] wr_data, rd_a, rd_b, coef_n, coef_s, in_val, core_res;
  logic        coef_we, idx_ok;
  core_req_t   core_req;
  core_rsp_t   core_rsp;
  logic [64:0] alu;

  // Result staging, then the output register.
  logic [47:0] res_x, res_px, res_y, res_py, res_ct;
  logic        out_load;

  function automatic logic [64:0] sat64(input logic [64:0] s);
    logic ovf;
    ovf = s[64] ^ s[63];
    if (ovf) return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [64:0] n48(input logic [63:0] v);
    if ($signed(v) > MAX48) return {1'b1, MAX48};
    if ($signed(v) < MIN48) return {1'b1, MIN48};
    return {1'b0, v};
  endfunction

  function automatic logic [63:0] sx(input logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  assign ins     = PROG[pc];
  assign top_lim = (5'(top_order) > LAST) ? LAST : 5'(top_order);
  assign n8      = 8'(n);
  assign idx_ok  = 6'(order_index) < 6'(NUM_ORDERS);

  mfk_coef_mem #(.DEPTH(NUM_ORDERS), .AW(AW)) u_coef (
    .clk     (clk),
    .rst     (rst),
    .we      (coef_we),
    .waddr   (AW'(order_index)),
    .wnormal (normal_value),
    .wskew   (skew_value),
    .raddr   (n),
    .rnormal (coef_n),
    .rskew   (coef_s)
  );

  mfk_var_mem u_vars (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (ins.d),
    .wdata   (wr_data),
    .raddr_a (ins.a),
    .raddr_b (ins.b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  mfk_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .req    (core_req),
    .op_a   (rd_a),
    .op_b   (rd_b),
    .result (core_res),
    .rsp    (core_rsp)
  );

  // Value picked by a load-input instruction.
  always_comb begin
    unique case (ins.a)
      IN_X:    in_val = sx(xi);
      IN_PX:   in_val = sx(pxi);
      IN_Y:    in_val = sx(yi);
      IN_PY:   in_val = sx(pyi);
      IN_DL:   in_val = sx(dli);
      IN_CT:   in_val = sx(cti);
      IN_ONE:  in_val = ONE;
      default: in_val = 64'd0;
    endcase
  end

  // Saturating local ops and a select; the top bit is the overflow flag.
  always_comb begin
    unique case (ins.op)
      OP_ADD:  alu = sat64({rd_a[63], rd_a} + {rd_b[63], rd_b});
      OP_SUB:  alu = sat64({rd_a[63], rd_a} - {rd_b[63], rd_b});
      OP_NEG:  alu = sat64(65'd0 - {rd_a[63], rd_a});
      OP_N48:  alu = n48(rd_a);
      OP_SELF: alu = {1'b0, flt ? rd_a : rd_b};
      default: alu = 65'd0;
    endcase
  end

  // Sequencer: each instruction reads its operands in the read state, then either
  // completes in the next or hands the operands to the shared unit. The
  // read cycle also keeps a write-back ahead of any read of the same entry.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    n_next     = n;
    flt_next   = flt;
    wr_en      = 1'b0;
    wr_data    = 64'd0;
    coef_we    = 1'b0;
    capture    = 1'b0;
    out_load   = 1'b0;
    in_ready   = (state == ST_IDLE);
    core_req   = '{start: 1'b0, mode: CM_MUL, kmag: '0, kneg: 1'b0, m: '0};
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (command == CMD_TRACK) begin
            capture    = 1'b1;
            pc_next    = '0;
            n_next     = '0;
            flt_next   = 1'b0;
            state_next = ST_READ;
          end else begin
            coef_we = idx_ok;
          end
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = ST_READ;
        pc_next    = pc + 7'd1;
        unique case (ins.op)
          OP_LDIN: begin
            wr_en   = 1'b1;
            wr_data = in_val;
          end
          OP_LDCN: begin
            wr_en   = 1'b1;
            wr_data = (skip_normal_dipole && n == '0) ? 64'd0 : coef_n;
          end
          OP_LDCS: begin
            wr_en   = 1'b1;
            wr_data = coef_s;
          end
          OP_ADD, OP_SUB, OP_NEG, OP_N48, OP_SELF: begin
            wr_en    = 1'b1;
            wr_data  = alu[63:0];
            flt_next = flt | alu[64];
          end
          OP_MUL: begin
            core_req.start = 1'b1;
            core_req.mode  = CM_MUL;
            state_next     = ST_WAIT;
            pc_next        = pc;
          end
          OP_DIV: begin
            core_req.start = 1'b1;
            core_req.mode  = CM_DIV;
            state_next     = ST_WAIT;
            pc_next        = pc;
          end
          OP_SCLE: begin
            // Scale by -edge_sign / (4 (j + 1)), j = n + 1.
            core_req.start = 1'b1;
            core_req.mode  = CM_SCL;
            core_req.kmag  = KW'(edge_sign != 2'b00);
            core_req.kneg  = (edge_sign == 2'b01);
            core_req.m     = MW'((n8 + 8'd2) << 2);
            state_next     = ST_WAIT;
            pc_next        = pc;
          end
          OP_SCLJ: begin
            core_req.start = 1'b1;
            core_req.mode  = CM_SCL;
            core_req.kmag  = KW'(n8 + 8'd1);
            core_req.m     = MW'(1);
            state_next     = ST_WAIT;
            pc_next        = pc;
          end
          OP_SCLP: begin
            core_req.start = 1'b1;
            core_req.mode  = CM_SCL;
            core_req.kmag  = KW'(n8 + 8'd3);
            core_req.m     = MW'(n8 + 8'd1);
            state_next     = ST_WAIT;
            pc_next        = pc;
          end
          OP_LOOP: begin
            if (5'(n) != top_lim) begin
              n_next  = n + AW'(1);
              pc_next = LOOP_START;
            end
          end
          OP_DONE: begin
            state_next = ST_DONE;
            pc_next    = pc;
          end
          default: ;
        endcase
      end
      ST_WAIT: begin
        if (core_rsp.done) begin
          wr_en      = 1'b1;
          wr_data    = core_res;
          flt_next   = flt | core_rsp.fault;
          pc_next    = pc + 7'd1;
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc                 <= '0;
      n                  <= '0;
      flt                <= 1'b0;
      out_valid          <= 1'b0;
      edge_sign          <= 2'b01;
      skip_normal_dipole <= 1'b0;
      top_order          <= 4'd0;
    end else begin
      pc  <= pc_next;
      n   <= n_next;
      flt <= flt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_EDGE_SIGN: edge_sign          <= cfg_data[1:0];
          CFG_SKIP_DIP:  skip_normal_dipole <= cfg_data[0];
          CFG_TOP_ORDER: top_order          <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: captured particle, staged results, output word.
  always_ff @(posedge clk) begin
    if (capture) begin
      xi  <= x_in;
      pxi <= px_in;
      yi  <= y_in;
      pyi <= py_in;
      dli <= delta_in;
      cti <= ct_in;
    end
    if (wr_en) begin
      if (ins.d == V_XO)  res_x  <= wr_data[47:0];
      if (ins.d == V_YO)  res_y  <= wr_data[47:0];
      if (ins.d == V_CTO) res_ct <= wr_data[47:0];
      if (ins.d == V_PXO) res_px <= wr_data[47:0];
      if (ins.d == V_PYO) res_py <= wr_data[47:0];
    end
    if (out_load) begin
      x_out  <= res_x;
      px_out <= res_px;
      y_out  <= res_y;
      py_out <= res_py;
      ct_out <= res_ct;
      fault  <= flt;
    end
  end

endmodule

[sv/mfk_coef_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfk_coef_mem: coefficient table
// One normal and one skew coefficient per order, one write and one
// registered read port; per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module mfk_coef_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wnormal,
  input  logic [63:0]   wskew,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rnormal,
  output logic [63:0]   rskew
);

  logic [127:0]     mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [127:0]     rdata;
  logic             rvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wnormal, wskew};
    end
    rdata  <= mem[raddr];
    rvalid <= valid[raddr];
  end

  assign rnormal = rvalid ? rdata[127:64] : 64'd0;
  assign rskew   = rvalid ? rdata[63:0]   : 64'd0;

endmodule

[sv/mfk_var_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfk_var_mem: working store
// Holds the particle coordinates and all intermediate terms; one write port
// and two registered read ports.
// ----------------------------------------------------------------------------
module mfk_var_mem (
  input  logic                clk,
  input  logic                we,
  input  logic [mfk_pkg::VAW-1:0] waddr,
  input  logic [63:0]         wdata,
  input  logic [mfk_pkg::VAW-1:0] raddr_a,
  input  logic [mfk_pkg::VAW-1:0] raddr_b,
  output logic [63:0]         rdata_a,
  output logic [63:0]         rdata_b
);
  import mfk_pkg::*;

  logic [63:0] mem [VDEP];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[sv/mfk_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfk_core: shared multiply-divide unit
// Computes round(|a|*|b'|/d) with sign, ties away from zero, saturated to
// 64 bits: a 32x32 multiplier over four partial products, then a shift or a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
module mfk_core #(
  parameter int FRAC_BITS = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  mfk_pkg::core_req_t  req,
  input  logic [63:0]         op_a,
  input  logic [63:0]         op_b,
  output logic [63:0]         result,
  output mfk_pkg::core_rsp_t  rsp
);
  import mfk_pkg::*;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  core_state_t  state, state_next;
  logic [63:0]  ua, ub, ud, rem, pp;
  logic [127:0] acc, quo, acc_sum, pp_sh;
  logic [1:0]   pp_code;
  logic [2:0]   step;
  logic [6:0]   cnt;
  logic         neg, is_mul, dz, done_r, fault_r;
  logic         div_zero_req, ge, rnd, sat;
  logic [64:0]  rem65;
  logic [63:0]  lim, magv;
  logic [31:0]  a_part, b_part;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  assign div_zero_req = (req.mode == CM_DIV) && (op_b == 64'd0);
  assign a_part  = step[1] ? ua[63:32] : ua[31:0];
  assign b_part  = step[0] ? ub[63:32] : ub[31:0];

  always_comb begin
    unique case (pp_code)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign acc_sum = acc + pp_sh;
  assign rem65   = {rem, quo[127]};
  assign ge      = rem65 >= {1'b0, ud};
  assign rnd     = rem >= (ud - rem);
  assign lim     = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign sat     = (quo[127:64] != 64'd0) || (quo[63:0] > lim);
  assign magv    = sat ? lim : quo[63:0];

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: if (req.start) state_next = div_zero_req ? CS_FIN : CS_MUL;
      CS_MUL:  if (step == 3'd4) state_next = (is_mul || ud == 64'd1) ? CS_RND : CS_DIV;
      CS_DIV:  if (cnt == 7'd127) state_next = CS_RND;
      CS_RND:  state_next = CS_FIN;
      CS_FIN:  state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= (state == CS_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CS_IDLE: begin
        if (req.start) begin
          ua     <= mag(op_a);
          step   <= 3'd0;
          acc    <= '0;
          quo    <= '0;
          rem    <= '0;
          dz     <= div_zero_req;
          is_mul <= (req.mode == CM_MUL);
          unique case (req.mode)
            CM_MUL: begin
              ub  <= mag(op_b);
              ud  <= ONE;
              neg <= op_a[63] ^ op_b[63];
            end
            CM_DIV: begin
              ub  <= ONE;
              ud  <= mag(op_b);
              neg <= op_a[63] ^ op_b[63];
            end
            default: begin
              ub  <= 64'(req.kmag);
              ud  <= 64'(req.m);
              neg <= op_a[63] ^ req.kneg;
            end
          endcase
        end
      end
      CS_MUL: begin
        pp      <= a_part * b_part;
        pp_code <= step[1:0];
        step    <= step + 3'd1;
        if (step != 3'd0) begin
          acc <= acc_sum;
        end
        if (step == 3'd4) begin
          cnt <= 7'd0;
          if (is_mul) begin
            quo <= acc_sum >> FRAC_BITS;
            rem <= 64'(acc_sum[FRAC_BITS-1:0]);
          end else begin
            quo <= acc_sum;
            rem <= 64'd0;
          end
        end
      end
      CS_DIV: begin
        rem <= ge ? 64'(rem65 - {1'b0, ud}) : rem65[63:0];
        quo <= {quo[126:0], ge};
        cnt <= cnt + 7'd1;
      end
      CS_RND: begin
        quo <= quo + 128'(rnd);
      end
      CS_FIN: begin
        if (dz) begin
          result  <= 64'd0;
          fault_r <= 1'b1;
        end else begin
          result  <= neg ? 64'd0 - magv : magv;
          fault_r <= sat;
        end
      end
      default: ;
    endcase
  end

  assign rsp = '{done: done_r, fault: fault_r};

endmodule

[bench/multipole_fringe_kick_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipole_fringe_kick_unit_tb: self-checking bench for the fringe map unit
// Loads coefficient tables and tracks particles under a range of edge, skip
// and top-order settings. Every track word is predicted in fixed point inside
// the bench and its result compared field by field, in order, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module multipole_fringe_kick_unit_tb;
  import mfk_pkg::*;

  localparam int     FRAC       = 40;
  localparam int     ORDERS     = 16;
  localparam longint ONE        = longint'(1) << FRAC;
  localparam longint S64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN    = 64'sh8000_0000_0000_0000;
  localparam longint S48_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN    = -S48_MAX - 1;
  localparam int     RAND_WORDS = 1650;
  localparam longint CYCLE_CAP  = 40_000_000;

  // One input word, as the block sees it on its input channel.
  typedef struct {
    logic              cmd;
    logic [3:0]        ord;
    logic signed [63:0] nval;
    logic signed [63:0] sval;
    logic signed [47:0] x, px, y, py, dl, ct;
  } word_t;

  // One result word of a track command.
  typedef struct {
    logic signed [47:0] x, px, y, py, ct;
    logic               flt;
  } kick_t;

  // The scoreboard keeps its own copy of the coefficient tables and the
  // registers, computes the map for every accepted track word and holds the
  // resulting words until the block delivers them.
  class fringe_map_checker;
    longint normal_coef[ORDERS];
    longint skew_coef[ORDERS];
    int     edge_factor;
    bit     skip_dipole;
    int     top_sel;
    bit     sat_flag;
    kick_t  expected_kicks[$];
    int     mismatches;

    function new();
      foreach (normal_coef[i]) begin
        normal_coef[i] = 0;
        skew_coef[i] = 0;
      end
      edge_factor = 1;
      skip_dipole = 0;
      top_sel = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_EDGE_SIGN: begin
          edge_factor = (val[1:0] == 2'd0) ? 0 : ((val[1:0] == 2'd1) ? 1 : -1);
        end
        CFG_SKIP_DIP: begin
          skip_dipole = val[0];
        end
        CFG_TOP_ORDER: begin
          top_sel = val;
        end
        default: ;
      endcase
    endfunction

    // Rounded, saturated magnitude product over divisor with the sign applied.
    function longint muldiv(bit [63:0] ua, bit [63:0] ub, bit [63:0] ud, bit ng);
      bit [127:0] p, q, r;
      bit [63:0]  lim;
      p = {64'd0, ua} * {64'd0, ub};
      q = p / {64'd0, ud};
      r = p % {64'd0, ud};
      if (r >= {64'd0, ud} - r) q = q + 1;
      lim = ng ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (q > {64'd0, lim}) begin
        sat_flag = 1;
        q = {64'd0, lim};
      end
      return ng ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function bit [63:0] mag(longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function longint fmul(longint a, longint b);
      return muldiv(mag(a), mag(b), 64'd1 << FRAC, (a < 0) != (b < 0));
    endfunction

    function longint fdiv(longint n, longint d);
      return muldiv(mag(n), 64'd1 << FRAC, mag(d), (n < 0) != (d < 0));
    endfunction

    function longint ratio(longint a, int k, int m);
      bit [63:0] uk;
      uk = (k < 0) ? -k : k;
      return muldiv(mag(a), uk, m, (a < 0) != (k < 0));
    endfunction

    function longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
        sat_flag = 1;
        return (a < 0) ? S64_MIN : S64_MAX;
      end
      return s;
    endfunction

    function longint sneg(longint a);
      if (a == S64_MIN) begin
        sat_flag = 1;
        return S64_MAX;
      end
      return -a;
    endfunction

    function longint ssub(longint a, longint b);
      if (b == S64_MIN) begin
        if (a >= 0) begin
          sat_flag = 1;
          return S64_MAX;
        end
        return sadd(sadd(a, S64_MAX), 1);
      end
      return sadd(a, -b);
    endfunction

    function longint clip48(longint a);
      if (a > S48_MAX) begin
        sat_flag = 1;
        return S48_MAX;
      end
      if (a < S48_MIN) begin
        sat_flag = 1;
        return S48_MIN;
      end
      return a;
    endfunction

    // Called for every word the block accepts.
    function void note_word(word_t w);
      longint x, y, px, py, dl, ct, rx, ix, drx, dix;
      longint fx, fy, fxx, fxy, fyx, fyy;
      longint bn, an, u, v, du, dv, dux, dvx, duy, dvy, nv, nx, ny;
      longint t, del, ma, mb, mc, md, xo, yo, det, pxo, pyo, qx, qy;
      int     top, j, es;
      bit     early;
      kick_t  k;
      if (w.cmd == CMD_LOAD) begin
        normal_coef[w.ord] = w.nval;
        skew_coef[w.ord] = w.sval;
        return;
      end
      sat_flag = 0;
      x = w.x; px = w.px; y = w.y; py = w.py; dl = w.dl; ct = w.ct;
      rx = ONE; ix = 0;
      fx = 0; fy = 0; fxx = 0; fxy = 0; fyx = 0; fyy = 0;
      es = edge_factor;
      top = (top_sel < ORDERS) ? top_sel : ORDERS - 1;
      for (int n = 0; n <= top; n++) begin
        bn = normal_coef[n];
        an = skew_coef[n];
        j = n + 1;
        drx = rx;
        dix = ix;
        rx = ssub(fmul(drx, x), fmul(dix, y));
        ix = sadd(fmul(drx, y), fmul(dix, x));
        if (n == 0 && skip_dipole) bn = 0;
        u  = ssub(fmul(bn, rx), fmul(an, ix));
        v  = sadd(fmul(bn, ix), fmul(an, rx));
        du = ssub(fmul(bn, drx), fmul(an, dix));
        dv = sadd(fmul(bn, dix), fmul(an, drx));
        u  = ratio(u, -es, 4 * (j + 1));
        v  = ratio(v, -es, 4 * (j + 1));
        du = ratio(du, -es, 4 * (j + 1));
        dv = ratio(dv, -es, 4 * (j + 1));
        dux = ratio(du, j, 1);
        dvx = ratio(dv, j, 1);
        duy = sneg(dvx);
        dvy = dux;
        nv = ratio(v, j + 2, j);
        nx = ratio(x, j + 2, j);
        ny = ratio(y, j + 2, j);
        fx  = sadd(fx, sadd(fmul(u, x), fmul(nv, y)));
        fy  = sadd(fy, ssub(fmul(u, y), fmul(nv, x)));
        fxx = sadd(fxx, sadd(sadd(fmul(dux, x), u), fmul(ny, dvx)));
        fxy = sadd(fxy, sadd(sadd(fmul(duy, x), nv), fmul(ny, dvy)));
        fyx = sadd(fyx, ssub(ssub(fmul(dux, y), nv), fmul(nx, dvx)));
        fyy = sadd(fyy, ssub(sadd(fmul(duy, y), u), fmul(nx, dvy)));
      end
      t = sadd(ONE, dl);
      if (t == 0) begin
        sat_flag = 1;
        del = 0;
      end else begin
        del = fdiv(ONE, t);
      end
      ma = ssub(ONE, fmul(fxx, del));
      mb = sneg(fmul(fyx, del));
      md = ssub(ONE, fmul(fyy, del));
      mc = sneg(fmul(fxy, del));
      xo = clip48(ssub(x, fmul(fx, del)));
      yo = clip48(ssub(y, fmul(fy, del)));
      det = ssub(fmul(ma, md), fmul(mb, mc));
      pxo = px;
      pyo = py;
      if (det == 0) begin
        sat_flag = 1;
      end else begin
        qx = clip48(fdiv(ssub(fmul(md, px), fmul(mb, py)), det));
        qy = clip48(fdiv(ssub(fmul(ma, py), fmul(mc, px)), det));
        if (!sat_flag) begin
          pxo = qx;
          pyo = qy;
        end
      end
      early = sat_flag;
      t = sadd(fmul(pxo, fx), fmul(pyo, fy));
      t = fmul(fmul(t, del), del);
      ct = clip48(ssub(ct, t));
      if (sat_flag && !early) begin
        pxo = px;
        pyo = py;
      end
      k.x = xo[47:0]; k.px = pxo[47:0]; k.y = yo[47:0];
      k.py = pyo[47:0]; k.ct = ct[47:0]; k.flt = sat_flag;
      expected_kicks.push_back(k);
    endfunction

    function void check_word(kick_t got);
      kick_t e;
      if (expected_kicks.size() == 0) begin
        $display("%0t: unexpected result word x=%h", $time, got.x);
        mismatches++;
        return;
      end
      e = expected_kicks.pop_front();
      if (got.x !== e.x) begin
        $display("%0t: x_out expected %h actual %h", $time, e.x, got.x);
        mismatches++;
      end
      if (got.px !== e.px) begin
        $display("%0t: px_out expected %h actual %h", $time, e.px, got.px);
        mismatches++;
      end
      if (got.y !== e.y) begin
        $display("%0t: y_out expected %h actual %h", $time, e.y, got.y);
        mismatches++;
      end
      if (got.py !== e.py) begin
        $display("%0t: py_out expected %h actual %h", $time, e.py, got.py);
        mismatches++;
      end
      if (got.ct !== e.ct) begin
        $display("%0t: ct_out expected %h actual %h", $time, e.ct, got.ct);
        mismatches++;
      end
      if (got.flt !== e.flt) begin
        $display("%0t: fault expected %b actual %b", $time, e.flt, got.flt);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic in_valid, in_ready, command;
  logic [3:0] order_index;
  logic signed [63:0] normal_value, skew_value;
  logic signed [47:0] x_in, px_in, y_in, py_in, delta_in, ct_in;
  logic out_valid, out_ready;
  logic signed [47:0] x_out, px_out, y_out, py_out, ct_out;
  logic fault;

  fringe_map_checker kicks = new();

  multipole_fringe_kick_unit dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .command, .order_index, .normal_value, .skew_value,
    .x_in, .px_in, .y_in, .py_in, .delta_in, .ct_in,
    .out_valid, .out_ready, .x_out, .px_out, .y_out, .py_out, .ct_out, .fault
  );

  always #5 clk = ~clk;

  // The run is cut short if it ever exceeds a very generous cycle budget.
  longint cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result words are sampled at the edge on which they are accepted.
  always @(posedge clk) begin
    kick_t got;
    if (!rst && out_valid && out_ready) begin
      got.x = x_out; got.px = px_out; got.y = y_out;
      got.py = py_out; got.ct = ct_out; got.flt = fault;
      kicks.check_word(got);
    end
  end

  // The receiver switches between always ready, about half ready and rarely
  // ready. Once, after some thirty results, it holds off for a long stretch
  // so that a result sits in the output register and the input backs up.
  int  ready_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  int  taken = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken <= taken + 1;
      if (!hold_done && taken == 30) begin
        hold_done <= 1;
        hold_left <= 40000;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode <= $urandom_range(0, 2);
          mode_left <= $urandom_range(64, 4000);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  // Offers one word in bursts with random gaps and waits for its acceptance.
  task automatic send_word(word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= w.cmd; order_index <= w.ord;
    normal_value <= w.nval; skew_value <= w.sval;
    x_in <= w.x; px_in <= w.px; y_in <= w.y;
    py_in <= w.py; delta_in <= w.dl; ct_in <= w.ct;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    kicks.note_word(w);
  endtask

  // Waits until every result has come back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (kicks.expected_kicks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One write, then the write port is left idle.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    kicks.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(int edge_pat, int skip, int top);
    drain();
    write_reg(CFG_EDGE_SIGN, edge_pat);
    write_reg(CFG_SKIP_DIP, skip);
    write_reg(CFG_TOP_ORDER, top);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Coordinates are mostly modest so that the map is exercised without
  // saturating; a share are extremes or fully random patterns.
  function automatic logic signed [47:0] pick_coord();
    logic [63:0] r;
    int w;
    r = rand64();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1)) ? S48_MAX[47:0] : S48_MIN[47:0];
      1, 2: return r[47:0];
      default: begin
        w = $urandom_range(16, 41);
        r = r & ((64'd1 << w) - 1);
        return ($urandom_range(0, 1)) ? -r[47:0] : r[47:0];
      end
    endcase
  endfunction

  function automatic logic signed [63:0] pick_coef();
    logic [63:0] r;
    int w;
    r = rand64();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1)) ? S64_MAX : S64_MIN;
      1: return r;
      2: return 0;
      default: begin
        w = $urandom_range(16, 43);
        r = r & ((64'd1 << w) - 1);
        return ($urandom_range(0, 1)) ? -r : r;
      end
    endcase
  endfunction

  function automatic word_t track(logic signed [47:0] x, px, y, py, dl, ct);
    word_t w;
    logic [63:0] r;
    r = rand64();
    w.cmd = CMD_TRACK; w.ord = r[3:0];
    w.nval = rand64(); w.sval = rand64();
    w.x = x; w.px = px; w.y = y; w.py = py; w.dl = dl; w.ct = ct;
    return w;
  endfunction

  function automatic word_t load(logic [3:0] k, logic signed [63:0] nv, sv);
    word_t w;
    logic [63:0] r;
    w.cmd = CMD_LOAD; w.ord = k; w.nval = nv; w.sval = sv;
    r = rand64(); w.x = r[47:0]; w.px = r[63:16];
    r = rand64(); w.y = r[47:0]; w.py = r[63:16];
    r = rand64(); w.dl = r[47:0]; w.ct = r[63:16];
    return w;
  endfunction

  function automatic word_t random_track();
    logic signed [47:0] dl;
    dl = ($urandom_range(0, 40) == 0) ? -ONE[47:0] : pick_coord();
    return track(pick_coord(), pick_coord(), pick_coord(), pick_coord(), dl, pick_coord());
  endfunction

  initial begin
    int sent, phase_len, top, edge_pat;
    rst <= 1'b1;
    cfg_write <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 1'b0; command <= CMD_LOAD; order_index <= '0;
    normal_value <= '0; skew_value <= '0;
    x_in <= '0; px_in <= '0; y_in <= '0; py_in <= '0; delta_in <= '0; ct_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset settings: zeros, extreme coordinates,
    // extreme coefficients and a momentum deviation that makes 1+delta zero.
    send_word(track(0, 0, 0, 0, 0, 0));
    send_word(track(S48_MAX, S48_MAX, S48_MIN, S48_MIN, 0, S48_MAX));
    send_word(load(4'd0, S64_MAX, S64_MIN));
    send_word(track(ONE, 0, ONE, 0, 0, 0));
    send_word(load(4'd0, ONE / 2, ONE / 4));
    send_word(track(ONE / 8, ONE / 16, -ONE / 8, ONE / 32, -ONE, ONE));
    send_word(track(ONE / 8, ONE / 16, -ONE / 8, ONE / 32, ONE / 64, -ONE));
    send_word(load(4'd15, S64_MIN, S64_MAX));

    // Edge pattern -2 acts as -1; with a normal dipole of eight and x of a
    // half the determinant comes out exactly zero. Skipping the dipole then
    // removes the kick altogether.
    configure(2, 0, 0);
    send_word(load(4'd0, 8 * ONE, 0));
    send_word(track(ONE / 2, ONE / 4, 0, -ONE / 4, 0, ONE / 2));
    configure(2, 1, 0);
    send_word(track(ONE / 2, ONE / 4, 0, -ONE / 4, 0, ONE / 2));

    // Zero edge factor, then the full table with the top order at its maximum.
    configure(0, 0, 15);
    send_word(track(ONE / 3, ONE / 5, ONE / 7, ONE / 9, ONE / 11, ONE / 13));
    configure(1, 0, 15);
    send_word(load(4'd15, ONE / 1024, -ONE / 2048));
    send_word(load(4'd7, -ONE / 16, ONE / 8));
    send_word(track(ONE / 4, ONE / 8, -ONE / 4, ONE / 16, 0, 0));
    send_word(track(ONE / 4, 0, ONE / 8, 0, S48_MIN, S48_MIN));

    // Random phases: mostly low top orders to keep the run short, now and
    // then the full table over only a handful of words.
    sent = 0;
    while (sent < RAND_WORDS) begin
      case ($urandom_range(0, 19))
        0: top = 15;
        1, 2, 3: top = $urandom_range(3, 6);
        default: top = $urandom_range(0, 2);
      endcase
      edge_pat = $urandom_range(0, 3);
      configure(edge_pat, $urandom_range(0, 1), top);
      phase_len = (top > 6) ? $urandom_range(6, 12) : $urandom_range(60, 160);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 4)
          send_word(load($urandom_range(0, ORDERS - 1), pick_coef(), pick_coef()));
        else
          send_word(random_track());
        sent++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (kicks.mismatches == 0 && kicks.expected_kicks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mfk_pkg.sv
sv/mfk_coef_mem.sv
sv/mfk_var_mem.sv
sv/mfk_core.sv
sv/multipole_fringe_kick_unit.sv
bench/multipole_fringe_kick_unit_tb.sv
